@@ rtl/matrix4x4_multiply_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros used by the matrix multiply port checker
// ---------------------------------------------------------------------------
`ifndef MATRIX4X4_MULTIPLY_UNIT_MACROS_SVH
`define MATRIX4X4_MULTIPLY_UNIT_MACROS_SVH

// Check a property outside reset
`define MM4_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every edge, reset included
`define MM4_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/mm4_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mm4_pkg
// Shared types, constants and helpers of the 4x4 fixed-point matrix multiply.
// ---------------------------------------------------------------------------
package mm4_pkg;

  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = $clog2(DIM);
  localparam int ADDR_W    = $clog2(DIM * DIM);
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = PROD_W + $clog2(DIM);
  localparam int SHR_W     = ACC_W - FRAC_BITS;

  typedef enum logic [1:0] {
    OP_LOAD_LEFT  = 2'd0,
    OP_LOAD_RIGHT = 2'd1,
    OP_COMPUTE    = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_clr;
  } mac_ctrl_t;

  // Row-major element address
  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    int a;
    a = int'(r) * DIM + int'(c);
    return ADDR_W'(a);
  endfunction

endpackage

@@ rtl/mm4_dot_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mm4_dot_unit
// Shared multiply-accumulate unit: one product per step, full-precision
// accumulation, arithmetic shift by the fraction width and saturation.
// ---------------------------------------------------------------------------
module mm4_dot_unit (
  input  logic                                clk_i,
  input  mm4_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [mm4_pkg::DATA_W-1:0]   a_i,
  input  logic signed [mm4_pkg::DATA_W-1:0]   b_i,
  output logic        [mm4_pkg::DATA_W-1:0]   sum_o
);
  import mm4_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [SHR_W-1:0]  shr;
  logic                     fits;

  // Register the product before it is accumulated
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= a_i * b_i;
    end
  end

  // Add the product, starting afresh on the first term of an element
  always_comb begin
    acc_d = (ctrl_i.acc_clr ? '0 : acc_q)
          + {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc_en) begin
      acc_q <= acc_d;
    end
  end

  // Drop the fraction bits and saturate to the output width
  always_comb begin
    shr  = acc_q[ACC_W-1:FRAC_BITS];
    fits = (shr[SHR_W-1:DATA_W-1] == '0) || (shr[SHR_W-1:DATA_W-1] == '1);
    if (fits) begin
      sum_o = shr[DATA_W-1:0];
    end else if (shr[SHR_W-1]) begin
      sum_o = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sum_o = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

endmodule

@@ rtl/matrix4x4_multiply_unit.sv @@
`timescale 1ns / 1ps
// Load items are written when accepted. A compute item produces 16 results,
// one shared multiply-accumulate unit building each from four terms that each
// pass through memory read, multiply and accumulate; a result then waits out
// any stall on the output side. No new item is taken until all 16 are taken.
// Reset (asynchronous, active low) clears both matrices to zero via per-entry
// valid bits and returns the sequencer to idle at once.
// ---------------------------------------------------------------------------
// matrix4x4_multiply_unit
// Holds left and right 4x4 Q16.16 matrices and streams their product out in
// row-major order, one saturated element per result item.
// ---------------------------------------------------------------------------
module matrix4x4_multiply_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          operation_i,
  input  logic [1:0]                          row_i,
  input  logic [1:0]                          col_i,
  input  logic signed [mm4_pkg::DATA_W-1:0]   value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          out_row_o,
  output logic [1:0]                          out_col_o,
  output logic signed [mm4_pkg::DATA_W-1:0]   product_o,
  output logic                                last_o
);
  import mm4_pkg::*;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIM - 1);

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    r_q, r_d, c_q, c_d, k_q, k_d;
  logic [DATA_W-1:0]   left_mem  [DIM*DIM];
  logic [DATA_W-1:0]   right_mem [DIM*DIM];
  logic [DIM*DIM-1:0]  left_vld_q, right_vld_q;
  logic [DATA_W-1:0]   la_q, rb_q;
  logic                la_vld_q, rb_vld_q;
  logic                in_acc, in_range, ld_left, ld_right;
  logic [ADDR_W-1:0]   wr_addr, la_addr, rb_addr;
  mac_ctrl_t           mac_ctrl;
  logic [DATA_W-1:0]   sum;

  // Decode load items
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_range   = (int'(row_i) < DIM) && (int'(col_i) < DIM);
  assign ld_left    = in_acc && in_range && (operation_i == OP_LOAD_LEFT);
  assign ld_right   = in_acc && in_range && (operation_i == OP_LOAD_RIGHT);
  assign wr_addr    = elem_addr(IDX_W'(row_i), IDX_W'(col_i));
  assign la_addr    = elem_addr(r_q, k_q);
  assign rb_addr    = elem_addr(k_q, c_q);

  // Write loaded elements, read one operand pair per step
  always_ff @(posedge clk_i) begin
    if (ld_left) begin
      left_mem[wr_addr] <= value_i;
    end
    if (ld_right) begin
      right_mem[wr_addr] <= value_i;
    end
    if (state_q == ST_READ) begin
      la_q <= left_mem[la_addr];
      rb_q <= right_mem[rb_addr];
    end
  end

  // Track written entries; an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_vld_q  <= '0;
      right_vld_q <= '0;
      la_vld_q    <= 1'b0;
      rb_vld_q    <= 1'b0;
    end else begin
      if (ld_left) begin
        left_vld_q[wr_addr] <= 1'b1;
      end
      if (ld_right) begin
        right_vld_q[wr_addr] <= 1'b1;
      end
      if (state_q == ST_READ) begin
        la_vld_q <= left_vld_q[la_addr];
        rb_vld_q <= right_vld_q[rb_addr];
      end
    end
  end

  // Sequencer state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      r_q     <= '0;
      c_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
      k_q     <= k_d;
    end
  end

  // Step through rows, columns and terms of each dot product
  always_comb begin
    state_d  = state_q;
    r_d      = r_q;
    c_d      = c_q;
    k_d      = k_q;
    mac_ctrl = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (operation_i == OP_COMPUTE)) begin
          r_d     = '0;
          c_d     = '0;
          k_d     = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        state_d         = ST_ACC;
      end
      ST_ACC: begin
        mac_ctrl.acc_en  = 1'b1;
        mac_ctrl.acc_clr = (k_q == '0);
        if (k_q == IDX_LAST) begin
          state_d = ST_OUT;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_READ;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          k_d     = '0;
          state_d = ST_READ;
          if (c_q == IDX_LAST) begin
            c_d = '0;
            if (r_q == IDX_LAST) begin
              r_d     = '0;
              state_d = ST_IDLE;
            end else begin
              r_d = r_q + 1'b1;
            end
          end else begin
            c_d = c_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  mm4_dot_unit u_dot (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (la_vld_q ? la_q : '0),
    .b_i    (rb_vld_q ? rb_q : '0),
    .sum_o  (sum)
  );

  // Present the finished element until it is taken
  assign out_valid_o = (state_q == ST_OUT);
  assign out_row_o   = 2'(r_q);
  assign out_col_o   = 2'(c_q);
  assign product_o   = sum;
  assign last_o      = (r_q == IDX_LAST) && (c_q == IDX_LAST);

endmodule

@@ rtl/mm4_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mm4_checker
// Port-level checks of the matrix multiply unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "matrix4x4_multiply_unit_macros.svh"

module mm4_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [1:0]                          out_row_o,
  input logic [1:0]                          out_col_o,
  input logic signed [mm4_pkg::DATA_W-1:0]   product_o,
  input logic                                last_o
);
  import mm4_pkg::*;

  localparam logic [1:0] POS_LAST = 2'(DIM - 1);

  // No new item is taken while a result is on offer
  `MM4_ASSERT(a_busy_when_out, out_valid_o |-> !in_ready_o, "input ready during output")

  // The final result carries the bottom-right position
  `MM4_ASSERT(a_last_pos, (out_valid_o && last_o) |-> ((out_row_o == POS_LAST) && (out_col_o == POS_LAST)), "last flag at wrong position")

  // Once the final result is taken the block is ready again
  `MM4_ASSERT(a_idle_after_last, (out_valid_o && out_ready_i && last_o) |=> in_ready_o, "not ready after last result")

  // A stalled result holds
  `MM4_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(product_o) && $stable(out_row_o) && $stable(out_col_o)), "stalled result changed")

endmodule

bind matrix4x4_multiply_unit mm4_checker u_mm4_checker (.*);

@@ tb/matrix4x4_multiply_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// matrix4x4_multiply_checker
// Watches both channels of the matrix multiply unit. It keeps its own copy of
// the left and right matrices and works out every product element when a
// compute item is taken. Each result item is then compared, field by field,
// with the oldest element still owed.
// ---------------------------------------------------------------------------
module matrix4x4_multiply_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [1:0]                        operation_i,
  input  logic [1:0]                        row_i,
  input  logic [1:0]                        col_i,
  input  logic signed [mm4_pkg::DATA_W-1:0] value_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [1:0]                        out_row_i,
  input  logic [1:0]                        out_col_i,
  input  logic signed [mm4_pkg::DATA_W-1:0] product_i,
  input  logic                              last_i,
  output int                                mismatch_count_o,
  output int                                owed_count_o
);
  import mm4_pkg::*;

  // Wide enough for four full 64-bit products without loss
  localparam int SUM_W = 2 * DATA_W + 2;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32'h7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - 1;

  typedef struct packed {
    logic [1:0]        row;
    logic [1:0]        col;
    logic [DATA_W-1:0] product;
    logic              last;
  } element_t;

  logic signed [DATA_W-1:0] left_q  [DIM][DIM];
  logic signed [DATA_W-1:0] right_q [DIM][DIM];
  element_t                 owed_elements[$];
  int                       mismatches;

  // Dot product of a left row and a right column, floor-shifted and saturated
  function automatic logic [DATA_W-1:0] dot_element(input int r, input int c);
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] lhs;
    logic signed [SUM_W-1:0] rhs;
    logic signed [SUM_W-1:0] scaled;
    sum = '0;
    for (int i = 0; i < DIM; i++) begin
      lhs = left_q[r][i];
      rhs = right_q[i][c];
      sum = sum + lhs * rhs;
    end
    scaled = sum >>> FRAC_BITS;
    if (scaled > SAT_HI) begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
    if (scaled < SAT_LO) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end
    return scaled[DATA_W-1:0];
  endfunction

  function automatic bit field_ok(input string name, input logic [DATA_W-1:0] want,
                                  input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Check results first, then take the input item of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    element_t want;
    if (!rst_ni) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          left_q[r][c]  = '0;
          right_q[r][c] = '0;
        end
      end
      owed_elements.delete();
      mismatches = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (owed_elements.size() == 0) begin
          $error("result item with no element owed: row %0d col %0d product %0h",
                 out_row_i, out_col_i, product_i);
          mismatches++;
        end else begin
          want = owed_elements.pop_front();
          if (!field_ok("out_row", DATA_W'(want.row), DATA_W'(out_row_i))) mismatches++;
          if (!field_ok("out_col", DATA_W'(want.col), DATA_W'(out_col_i))) mismatches++;
          if (!field_ok("product", want.product, product_i)) mismatches++;
          if (!field_ok("last", DATA_W'(want.last), DATA_W'(last_i))) mismatches++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (operation_i)
          OP_LOAD_LEFT: begin
            left_q[row_i][col_i] = value_i;
          end
          OP_LOAD_RIGHT: begin
            right_q[row_i][col_i] = value_i;
          end
          OP_COMPUTE: begin
            for (int r = 0; r < DIM; r++) begin
              for (int c = 0; c < DIM; c++) begin
                want.row     = 2'(r);
                want.col     = 2'(c);
                want.product = dot_element(r, c);
                want.last    = (r == DIM - 1) && (c == DIM - 1);
                owed_elements.push_back(want);
              end
            end
          end
          default: begin
            // unused operation: drop the item
          end
        endcase
      end
    end
    mismatch_count_o <= mismatches;
    owed_count_o     <= owed_elements.size();
  end

endmodule

@@ tb/tb_matrix4x4_multiply_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_matrix4x4_multiply_unit
// Drives load and compute items into the matrix multiply unit: a directed
// opening on extreme values, saturation and rounding, then random loads and
// computes with random gaps, output stalls and one long output hold-off.
// ---------------------------------------------------------------------------
module tb_matrix4x4_multiply_unit;
  import mm4_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 250;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [DATA_W-1:0] MAX_POS = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] MAX_NEG = 32'h8000_0000;
  localparam logic [DATA_W-1:0] ONE_Q   = 32'h0001_0000;

  logic                     clk_i     = 1'b0;
  logic                     rst_ni    = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic [1:0]               operation = OP_LOAD_LEFT;
  logic [1:0]               row       = 2'd0;
  logic [1:0]               col       = 2'd0;
  logic signed [DATA_W-1:0] value     = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               out_row;
  logic [1:0]               out_col;
  logic signed [DATA_W-1:0] product;
  logic                     last;
  logic                     calm      = 1'b0;
  logic                     hold_off  = 1'b0;
  int                       mismatch_count;
  int                       owed_count;
  int                       cycle_count = 0;

  matrix4x4_multiply_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .operation_i (operation),
    .row_i       (row),
    .col_i       (col),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_row_o   (out_row),
    .out_col_o   (out_col),
    .product_o   (product),
    .last_o      (last)
  );

  matrix4x4_multiply_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .operation_i      (operation),
    .row_i            (row),
    .col_i            (col),
    .value_i          (value),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_row_i        (out_row),
    .out_col_i        (out_col),
    .product_i        (product),
    .last_i           (last),
    .mismatch_count_o (mismatch_count),
    .owed_count_o     (owed_count)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one item, after an occasional idle gap, and hold it until taken
  task automatic offer_item(input logic [1:0] op, input logic [1:0] r, input logic [1:0] c,
                            input logic [DATA_W-1:0] v);
    if (!calm && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    operation <= op;
    row       <= r;
    col       <= c;
    value     <= v;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // Mix of full-range, small Q16.16 and extreme element values
  function automatic logic [DATA_W-1:0] pick_value();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      return $urandom();
    end
    if (kind < 8) begin
      return DATA_W'(int'($urandom_range(0, 1048575)) - 524288);
    end
    case ($urandom_range(0, 4))
      0: return MAX_POS;
      1: return MAX_NEG;
      2: return '0;
      3: return '1;
      default: return ONE_Q;
    endcase
  endfunction

  // Receiver: random stalls, a calm stretch, and one long hold-off
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off && !held) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        held = 1'b1;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  // Sender and verdict
  initial begin
    int pick;
    logic [1:0] op;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Product of the cleared matrices, then an unused operation
    offer_item(OP_COMPUTE, 2'd0, 2'd0, '0);
    offer_item(OP_UNUSED, 2'd3, 2'd3, MAX_POS);
    // Most negative row times most negative column: saturate high
    for (int i = 0; i < DIM; i++) begin
      offer_item(OP_LOAD_LEFT, 2'd0, 2'(i), MAX_NEG);
      offer_item(OP_LOAD_RIGHT, 2'(i), 2'd0, MAX_NEG);
    end
    // Most negative times most positive: saturate low
    offer_item(OP_LOAD_RIGHT, 2'd0, 2'd2, MAX_POS);
    offer_item(OP_LOAD_RIGHT, 2'd0, 2'd3, ONE_Q);
    // Minus one LSB times one LSB: floor shift gives minus one
    offer_item(OP_LOAD_LEFT, 2'd1, 2'd0, '1);
    offer_item(OP_LOAD_RIGHT, 2'd0, 2'd1, 32'd1);
    // Ordinary fractions and most positive squared
    offer_item(OP_LOAD_LEFT, 2'd2, 2'd1, ONE_Q);
    offer_item(OP_LOAD_RIGHT, 2'd1, 2'd2, 32'h0001_8000);
    offer_item(OP_LOAD_LEFT, 2'd3, 2'd3, MAX_POS);
    offer_item(OP_LOAD_RIGHT, 2'd3, 2'd3, MAX_POS);
    offer_item(OP_COMPUTE, 2'd1, 2'd2, '1);
    offer_item(OP_UNUSED, 2'd0, 2'd0, '0);

    // Hold the output while one compute runs and a second waits behind it
    hold_off <= 1'b1;
    offer_item(OP_COMPUTE, 2'd0, 2'd0, '0);
    offer_item(OP_COMPUTE, 2'd3, 2'd3, '1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 90) calm <= 1'b1;
      if (n == 140) calm <= 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        op = OP_UNUSED;
      end else if (pick < 12) begin
        op = OP_COMPUTE;
      end else if (pick % 2 == 0) begin
        op = OP_LOAD_LEFT;
      end else begin
        op = OP_LOAD_RIGHT;
      end
      offer_item(op, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), pick_value());
    end
    in_valid <= 1'b0;
    @(posedge clk_i);

    // Drain every owed element, then allow for the block's latency
    while (owed_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
